/* src/ecpa_pkg.sv */
// Shared constants and types for the elliptic-curve point add / scalar multiply block.
// No dependencies.
package ecpa_pkg;

  localparam int WIDTH_DEF       = 16;
  localparam int SCALAR_BITS_DEF = 16;
  localparam int FIELD_W         = 16;
  localparam int CFG_IDX_W       = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS = 1'b0,
    REG_CURVE_A = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    FUNC_ADD = 1'b0,
    FUNC_MUL = 1'b1
  } func_t;

  // handshake between the sequencer and one of its arithmetic units
  typedef struct packed {
    logic start;
    logic done;
  } unit_hs_t;

endpackage

/* src/ecpa_mul.sv */
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on ecpa_pkg.
module ecpa_mul #(
  parameter int W = ecpa_pkg::WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] prod
);
  import ecpa_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  sh_r, sh_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;

  function automatic logic [W-1:0] madd(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] mm);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, mm}) s = s - {1'b0, mm};
    return s[W-1:0];
  endfunction

  always_comb begin
    logic [W-1:0] d;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    d = madd(acc_r, acc_r, m);
    if (sh_r[W-1]) d = madd(d, b, m);
    if (start) begin
      acc_nxt = '0;
      sh_nxt  = a;
      cnt_nxt = CW'(W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      acc_nxt = d;
      sh_nxt  = sh_r << 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* src/ecpa_inv.sv */
// Modular inverse by extended Euclid, quotients built from shifted subtractions.
// Depends on ecpa_pkg. Returns zero when the value is not invertible.
module ecpa_inv #(
  parameter int W = ecpa_pkg::WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] v,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] inv
);
  import ecpa_pkg::*;

  typedef enum logic [3:0] {
    I_IDLE  = 4'b0001,
    I_TEST  = 4'b0010,
    I_ALIGN = 4'b0100,
    I_SUB   = 4'b1000
  } inv_state_t;

  inv_state_t   state_r, state_nxt;
  logic [W-1:0] a_r, a_nxt, ta_r, ta_nxt;
  logic [W-1:0] b_r, b_nxt, tb_r, tb_nxt;
  logic [W-1:0] bs_r, bs_nxt, ts_r, ts_nxt;
  logic [W-1:0] res_r, res_nxt;
  logic         done_r, done_nxt;

  function automatic logic [W-1:0] madd(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] mm);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, mm}) s = s - {1'b0, mm};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] msub(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] mm);
    logic [W:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else        s = {1'b0, x} + {1'b0, mm} - {1'b0, y};
    return s[W-1:0];
  endfunction

  always_comb begin
    logic [W:0] bs2;
    state_nxt = state_r;
    a_nxt     = a_r;
    ta_nxt    = ta_r;
    b_nxt     = b_r;
    tb_nxt    = tb_r;
    bs_nxt    = bs_r;
    ts_nxt    = ts_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    bs2       = {bs_r, 1'b0};
    unique case (state_r)
      I_IDLE: begin
        if (start) begin
          a_nxt     = m;
          ta_nxt    = '0;
          b_nxt     = v;
          tb_nxt    = W'(1);
          state_nxt = I_TEST;
        end
      end
      I_TEST: begin
        if (b_r == '0) begin
          res_nxt   = (a_r == W'(1)) ? ta_r : '0;
          done_nxt  = 1'b1;
          state_nxt = I_IDLE;
        end else if (a_r < b_r) begin
          a_nxt  = b_r;
          ta_nxt = tb_r;
          b_nxt  = a_r;
          tb_nxt = ta_r;
        end else begin
          bs_nxt    = b_r;
          ts_nxt    = tb_r;
          state_nxt = I_ALIGN;
        end
      end
      I_ALIGN: begin
        if (bs2 <= {1'b0, a_r}) begin
          bs_nxt = bs2[W-1:0];
          ts_nxt = madd(ts_r, ts_r, m);
        end else begin
          state_nxt = I_SUB;
        end
      end
      I_SUB: begin
        a_nxt     = a_r - bs_r;
        ta_nxt    = msub(ta_r, ts_r, m);
        state_nxt = I_TEST;
      end
      default: state_nxt = I_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= I_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    a_r   <= a_nxt;
    ta_r  <= ta_nxt;
    b_r   <= b_nxt;
    tb_r  <= tb_nxt;
    bs_r  <= bs_nxt;
    ts_r  <= ts_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign inv  = res_r;

endmodule

/* src/ec_point_add_scalar_multiply_top.sv */
// Elliptic-curve point addition and scalar multiplication over GF(modulus).
// Depends on ecpa_pkg, ecpa_mul and ecpa_inv.
//
//   channel | ports                                   | direction
//   in      | in_valid/in_stall, func, P, Q, scalar    | into block
//   out     | out_valid/out_stall, r_x, r_y, r_infinity| out of block
//   cfg     | cfg_we, cfg_index, cfg_wdata             | into block
//
// One item at a time. Input reduction passes the five input values (P, Q and a)
// through the serial multiplier; each point operation uses up to four serial
// multiplications plus the Euclid inverse. Scalar multiply runs up to
// 2*SCALAR_BITS point operations. A finished result waits in the output
// register while the next item is taken. Reset sets modulus 17 and a = 2.
module ec_point_add_scalar_multiply_top #(
  parameter int WIDTH       = ecpa_pkg::WIDTH_DEF,
  parameter int SCALAR_BITS = ecpa_pkg::SCALAR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic [ecpa_pkg::FIELD_W-1:0]     in_p_x,
  input  logic [ecpa_pkg::FIELD_W-1:0]     in_p_y,
  input  logic                             in_p_infinity,
  input  logic [ecpa_pkg::FIELD_W-1:0]     in_q_x,
  input  logic [ecpa_pkg::FIELD_W-1:0]     in_q_y,
  input  logic                             in_q_infinity,
  input  logic [ecpa_pkg::FIELD_W-1:0]     in_scalar,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ecpa_pkg::FIELD_W-1:0]     out_r_x,
  output logic [ecpa_pkg::FIELD_W-1:0]     out_r_y,
  output logic                             out_r_infinity,
  input  logic                             cfg_we,
  input  logic [ecpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ecpa_pkg::FIELD_W-1:0]     cfg_wdata
);
  import ecpa_pkg::*;

  localparam int W    = WIDTH;
  localparam int SB   = SCALAR_BITS;
  localparam int CNW  = $clog2(SB + 1);
  localparam logic [2:0] LD_LAST = 3'd4;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_LOAD  = 18'h00002,
    S_START = 18'h00004,
    S_CHK   = 18'h00008,
    S_DMUL  = 18'h00010,
    S_DA1   = 18'h00020,
    S_DA2   = 18'h00040,
    S_DA3   = 18'h00080,
    S_INV   = 18'h00100,
    S_SMUL  = 18'h00200,
    S_SQ    = 18'h00400,
    S_X1    = 18'h00800,
    S_X2    = 18'h01000,
    S_D     = 18'h02000,
    S_YMUL  = 18'h04000,
    S_Y     = 18'h08000,
    S_NEXT  = 18'h10000,
    S_OUT   = 18'h20000
  } state_t;

  function automatic logic [W-1:0] fit(input logic [FIELD_W-1:0] x);
    logic [W+FIELD_W-1:0] e;
    e = {{W{1'b0}}, x};
    return e[W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic [W-1:0] x);
    logic [W+FIELD_W-1:0] e;
    e = {{FIELD_W{1'b0}}, x};
    return e[FIELD_W-1:0];
  endfunction

  function automatic logic [SB-1:0] fitk(input logic [FIELD_W-1:0] x);
    logic [SB+FIELD_W-1:0] e;
    e = {{SB{1'b0}}, x};
    return e[SB-1:0];
  endfunction

  function automatic logic [W-1:0] madd(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] mm);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, mm}) s = s - {1'b0, mm};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] msub(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] mm);
    logic [W:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else        s = {1'b0, x} + {1'b0, mm} - {1'b0, y};
    return s[W-1:0];
  endfunction

  state_t               state_r, state_nxt;
  logic [FIELD_W-1:0]   mod_r, mod_nxt, cacfg_r, cacfg_nxt;
  logic                 func_r, func_nxt;
  logic [W-1:0]         px_r, px_nxt, py_r, py_nxt;
  logic                 pinf_r, pinf_nxt;
  logic [W-1:0]         ax_r, ax_nxt, ay_r, ay_nxt;
  logic                 ainf_r, ainf_nxt;
  logic [W-1:0]         bx_r, bx_nxt, by_r, by_nxt;
  logic                 binf_r, binf_nxt;
  logic [W-1:0]         ca_r, ca_nxt;
  logic [W-1:0]         u_r, u_nxt, v_r, v_nxt, s_r, s_nxt, t_r, t_nxt, x3_r, x3_nxt;
  logic [SB-1:0]        k_r, k_nxt;
  logic [CNW-1:0]       cnt_r, cnt_nxt;
  logic                 phase_r, phase_nxt;
  logic [2:0]           ld_r, ld_nxt;
  logic                 issued_r, issued_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [FIELD_W-1:0]   ox_r, ox_nxt, oy_r, oy_nxt;
  logic                 oinf_r, oinf_nxt;

  logic [W-1:0] m_w;
  logic         m_small;
  logic         in_xfer, out_hold;
  unit_hs_t     mul_hs, inv_hs;
  logic [W-1:0] mul_a, mul_b, mul_p, inv_p;
  logic         mul_state;

  assign m_w      = fit(mod_r);
  assign m_small  = (m_w[W-1:1] == '0);
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_hold = ovalid_r && out_stall;

  assign mul_state = (state_r == S_LOAD) || (state_r == S_DMUL) || (state_r == S_SMUL) ||
                     (state_r == S_SQ) || (state_r == S_YMUL);
  assign mul_hs.start = mul_state && !issued_r;
  assign inv_hs.start = (state_r == S_INV) && !issued_r;

  always_comb begin
    mul_a = ax_r;
    mul_b = ax_r;
    unique case (state_r)
      S_LOAD: begin
        mul_b = W'(1);
        unique case (ld_r)
          3'd0:    mul_a = px_r;
          3'd1:    mul_a = py_r;
          3'd2:    mul_a = bx_r;
          3'd3:    mul_a = by_r;
          default: mul_a = ca_r;
        endcase
      end
      S_SMUL: begin
        mul_a = u_r;
        mul_b = v_r;
      end
      S_SQ: begin
        mul_a = s_r;
        mul_b = s_r;
      end
      S_YMUL: begin
        mul_a = s_r;
        mul_b = t_r;
      end
      default: begin
        mul_a = ax_r;
        mul_b = ax_r;
      end
    endcase
  end

  ecpa_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_hs.start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (m_w),
    .done  (mul_hs.done),
    .prod  (mul_p)
  );

  ecpa_inv #(.W(W)) u_inv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (inv_hs.start),
    .v     (v_r),
    .m     (m_w),
    .done  (inv_hs.done),
    .inv   (inv_p)
  );

  always_comb begin
    state_nxt  = state_r;
    mod_nxt    = mod_r;
    cacfg_nxt  = cacfg_r;
    func_nxt   = func_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    pinf_nxt   = pinf_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    ainf_nxt   = ainf_r;
    bx_nxt     = bx_r;
    by_nxt     = by_r;
    binf_nxt   = binf_r;
    ca_nxt     = ca_r;
    u_nxt      = u_r;
    v_nxt      = v_r;
    s_nxt      = s_r;
    t_nxt      = t_r;
    x3_nxt     = x3_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    ld_nxt     = ld_r;
    issued_nxt = issued_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oinf_nxt   = oinf_r;
    ovalid_nxt = out_hold;

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODULUS: mod_nxt   = cfg_wdata;
        REG_CURVE_A: cacfg_nxt = cfg_wdata;
        default:     mod_nxt   = mod_r;
      endcase
    end

    if (mul_hs.start || inv_hs.start) issued_nxt = 1'b1;
    if (mul_hs.done || inv_hs.done)   issued_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          func_nxt = in_func;
          px_nxt   = fit(in_p_x);
          py_nxt   = fit(in_p_y);
          pinf_nxt = in_p_infinity;
          bx_nxt   = fit(in_q_x);
          by_nxt   = fit(in_q_y);
          binf_nxt = in_q_infinity;
          k_nxt    = fitk(in_scalar);
          ca_nxt   = fit(cacfg_r);
          ld_nxt   = '0;
          if (m_small) begin
            ainf_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        if (mul_hs.done) begin
          unique case (ld_r)
            3'd0:    px_nxt = mul_p;
            3'd1:    py_nxt = mul_p;
            3'd2:    bx_nxt = mul_p;
            3'd3:    by_nxt = mul_p;
            default: ca_nxt = mul_p;
          endcase
          ld_nxt = ld_r + 3'd1;
          if (ld_r == LD_LAST) state_nxt = S_START;
        end
      end
      S_START: begin
        if (func_t'(func_r) == FUNC_ADD) begin
          ax_nxt   = px_r;
          ay_nxt   = py_r;
          ainf_nxt = pinf_r;
        end else begin
          ax_nxt    = '0;
          ay_nxt    = '0;
          ainf_nxt  = 1'b1;
          bx_nxt    = '0;
          by_nxt    = '0;
          binf_nxt  = 1'b1;
          cnt_nxt   = CNW'(SB - 1);
          phase_nxt = 1'b0;
        end
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (ainf_r) begin
          ax_nxt    = bx_r;
          ay_nxt    = by_r;
          ainf_nxt  = binf_r;
          state_nxt = S_NEXT;
        end else if (binf_r) begin
          state_nxt = S_NEXT;
        end else if (ax_r == bx_r && by_r == msub('0, ay_r, m_w)) begin
          ax_nxt    = '0;
          ay_nxt    = '0;
          ainf_nxt  = 1'b1;
          state_nxt = S_NEXT;
        end else if (ax_r == bx_r && ay_r == by_r) begin
          state_nxt = S_DMUL;
        end else begin
          u_nxt     = msub(by_r, ay_r, m_w);
          v_nxt     = msub(bx_r, ax_r, m_w);
          state_nxt = S_INV;
        end
      end
      S_DMUL: begin
        if (mul_hs.done) begin
          t_nxt     = mul_p;
          state_nxt = S_DA1;
        end
      end
      S_DA1: begin
        u_nxt     = madd(t_r, t_r, m_w);
        state_nxt = S_DA2;
      end
      S_DA2: begin
        u_nxt     = madd(u_r, t_r, m_w);
        state_nxt = S_DA3;
      end
      S_DA3: begin
        u_nxt     = madd(u_r, ca_r, m_w);
        v_nxt     = madd(ay_r, ay_r, m_w);
        state_nxt = S_INV;
      end
      S_INV: begin
        if (inv_hs.done) begin
          v_nxt     = inv_p;
          state_nxt = S_SMUL;
        end
      end
      S_SMUL: begin
        if (mul_hs.done) begin
          s_nxt     = mul_p;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (mul_hs.done) begin
          t_nxt     = mul_p;
          state_nxt = S_X1;
        end
      end
      S_X1: begin
        x3_nxt    = msub(t_r, ax_r, m_w);
        state_nxt = S_X2;
      end
      S_X2: begin
        x3_nxt    = msub(x3_r, bx_r, m_w);
        state_nxt = S_D;
      end
      S_D: begin
        t_nxt     = msub(ax_r, x3_r, m_w);
        state_nxt = S_YMUL;
      end
      S_YMUL: begin
        if (mul_hs.done) begin
          t_nxt     = mul_p;
          state_nxt = S_Y;
        end
      end
      S_Y: begin
        ay_nxt    = msub(t_r, ay_r, m_w);
        ax_nxt    = x3_r;
        ainf_nxt  = 1'b0;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (func_t'(func_r) == FUNC_ADD) begin
          state_nxt = S_OUT;
        end else if (!phase_r && k_r[SB-1]) begin
          phase_nxt = 1'b1;
          bx_nxt    = px_r;
          by_nxt    = py_r;
          binf_nxt  = pinf_r;
          state_nxt = S_CHK;
        end else if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt   = cnt_r - CNW'(1);
          k_nxt     = k_r << 1;
          phase_nxt = 1'b0;
          bx_nxt    = ax_r;
          by_nxt    = ay_r;
          binf_nxt  = ainf_r;
          state_nxt = S_CHK;
        end
      end
      S_OUT: begin
        if (!out_hold) begin
          ovalid_nxt = 1'b1;
          ox_nxt     = ainf_r ? '0 : to_field(ax_r);
          oy_nxt     = ainf_r ? '0 : to_field(ay_r);
          oinf_nxt   = ainf_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mod_r    <= FIELD_W'(17);
      cacfg_r  <= FIELD_W'(2);
      issued_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mod_r    <= mod_nxt;
      cacfg_r  <= cacfg_nxt;
      issued_r <= issued_nxt;
      ovalid_r <= ovalid_nxt;
    end
    func_r  <= func_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    pinf_r  <= pinf_nxt;
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    ainf_r  <= ainf_nxt;
    bx_r    <= bx_nxt;
    by_r    <= by_nxt;
    binf_r  <= binf_nxt;
    ca_r    <= ca_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    s_r     <= s_nxt;
    t_r     <= t_nxt;
    x3_r    <= x3_nxt;
    k_r     <= k_nxt;
    cnt_r   <= cnt_nxt;
    phase_r <= phase_nxt;
    ld_r    <= ld_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oinf_r  <= oinf_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_r_x        = ox_r;
  assign out_r_y        = oy_r;
  assign out_r_infinity = oinf_r;

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_hs.done && inv_hs.done))
    else $error("multiplier and inverse finished together");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_LOAD || state_r == S_OUT))
    else $error("accepted transfer did not start work");

  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) && oinf_r |-> (ox_r == '0 && oy_r == '0))
    else $error("infinity result with nonzero coordinates");

  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && !ainf_r |-> (ax_r < m_w && ay_r < m_w))
    else $error("result coordinate not reduced");

endmodule
